// ===== sv/complex_arith_unit_top_macros.svh =====
// Assertion helpers shared by the RTL; clock and reset are the design's own.
`ifndef COMPLEX_ARITH_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITH_UNIT_TOP_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define CAU_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("complex_arith_unit: check failed");

// ante holds -> cons holds in the next cycle
`define CAU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("complex_arith_unit: check failed");

`endif

// ===== sv/cau_pkg.sv =====
package cau_pkg;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SUB = 2'd1;
   localparam logic [1:0] FUNC_MUL = 2'd2;
   localparam logic [1:0] FUNC_DIV = 2'd3;

   localparam int QUO_W = 33;            // quotient bits produced by the divider
   localparam int REM_W = 64 + QUO_W;    // remainder width, holds den << 33
   localparam int DIV_STAGES = QUO_W;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   // products and add/sub results after the first stage
   typedef struct packed {
      logic [1:0]         func;
      logic signed [63:0] p_rr;   // a_re*b_re
      logic signed [63:0] p_ii;   // a_im*b_im
      logic signed [63:0] p_ri;   // a_re*b_im
      logic signed [63:0] p_ir;   // a_im*b_re
      logic signed [63:0] p_bb_r; // b_re*b_re
      logic signed [63:0] p_bb_i; // b_im*b_im
      logic signed [32:0] s_re;
      logic signed [32:0] s_im;
   } cau_prod_type;

   // one result part in sign/magnitude form, with divider state
   typedef struct packed {
      logic             neg;
      logic [63:0]      mag;
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             big;
   } cau_part_type;

   typedef struct packed {
      logic         is_div;
      logic         dz;
      logic [63:0]  den;
      cau_part_type re;
      cau_part_type im;
   } cau_stage_type;

   // one restoring step: compare against the shifted divisor, shift in a quotient bit
   function automatic cau_part_type div_step(cau_part_type p, logic [REM_W-1:0] dsh);
      cau_part_type r;
      logic         ge;
      r  = p;
      ge = (p.rem >= dsh);
      if (ge) begin
         r.rem = p.rem - dsh;
      end
      r.quo = {p.quo[QUO_W-2:0], ge};
      return r;
   endfunction

   function automatic logic [31:0] sat32(logic neg, logic [63:0] mag, output logic ovf);
      logic [31:0] res;
      ovf = 1'b0;
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            ovf = 1'b1;
            res = SAT_NEG;
         end else begin
            res = 32'(~mag + 64'd1);
         end
      end else begin
         if (mag > 64'h7FFF_FFFF) begin
            ovf = 1'b1;
            res = SAT_POS;
         end else begin
            res = mag[31:0];
         end
      end
      return res;
   endfunction

endpackage

// ===== sv/complex_arith_unit_top.sv =====
// Channel   Ports                                            Dir
// request   req_valid/ready, req_func, req_a_re/a_im/b_re/b_im  in
// response  rsp_valid/ready, rsp_res_re/res_im, rsp_overflow,   out
//           rsp_div_zero
//
// One item per cycle while the response is not stalled. Stages: two multiply/sum stages, one
// restoring-divide stage per quotient bit (33), and the saturating output register.
// Every operation flows through all stages, so results leave in order.
// Synchronous reset clears only the valid bits; no clearing pass.
// A stalled response backs up stage by stage; empty stages keep taking items.
`include "complex_arith_unit_top_macros.svh"

module complex_arith_unit_top
   import cau_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic signed [31:0]  req_a_re,
   input  logic signed [31:0]  req_a_im,
   input  logic signed [31:0]  req_b_re,
   input  logic signed [31:0]  req_b_im,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_res_re,
   output logic signed [31:0]  rsp_res_im,
   output logic                rsp_overflow,
   output logic                rsp_div_zero
);

   logic          f_valid, f_ready, d_valid, d_ready;
   cau_stage_type f_data, d_data;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .func      (req_func),
      .a_re      (req_a_re),
      .a_im      (req_a_im),
      .b_re      (req_b_re),
      .b_im      (req_b_im),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   cau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_data  (d_data)
   );

   cau_sat u_sat (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (d_valid),
      .in_ready     (d_ready),
      .in_data      (d_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_res_re   (rsp_res_re),
      .rsp_res_im   (rsp_res_im),
      .rsp_overflow (rsp_overflow),
      .rsp_div_zero (rsp_div_zero)
   );

   `CAU_ASSERT_IMPL(a_dz_div_only, rsp_valid && rsp_div_zero, !rsp_overflow)
   `CAU_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_res_re))
   `CAU_ASSERT_NEXT(a_hold_im, rsp_valid && !rsp_ready, $stable({rsp_res_im, rsp_overflow}))

endmodule

// ===== sv/cau_front.sv =====
module cau_front
   import cau_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          func,
   input  logic signed [31:0]  a_re,
   input  logic signed [31:0]  a_im,
   input  logic signed [31:0]  b_re,
   input  logic signed [31:0]  b_im,
   output logic                out_valid,
   input  logic                out_ready,
   output cau_stage_type       out_data
);

   cau_prod_type  prod_ff, prod_in;
   cau_stage_type st_ff, st_in;
   logic          v1_ff, v2_ff;
   logic          rdy1, rdy2;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      prod_in.func   = func;
      prod_in.p_rr   = a_re * b_re;
      prod_in.p_ii   = a_im * b_im;
      prod_in.p_ri   = a_re * b_im;
      prod_in.p_ir   = a_im * b_re;
      prod_in.p_bb_r = b_re * b_re;
      prod_in.p_bb_i = b_im * b_im;
      if (func == FUNC_SUB) begin
         prod_in.s_re = 33'(a_re) - 33'(b_re);
         prod_in.s_im = 33'(a_im) - 33'(b_im);
      end else begin
         prod_in.s_re = 33'(a_re) + 33'(b_re);
         prod_in.s_im = 33'(a_im) + 33'(b_im);
      end
   end

   // exact 65-bit sums, then sign/magnitude
   always_comb begin
      logic signed [64:0] sre, sim, are, aim;
      logic [63:0]        den;
      case (prod_ff.func)
         FUNC_MUL: begin
            sre = 65'(prod_ff.p_rr) - 65'(prod_ff.p_ii);
            sim = 65'(prod_ff.p_ri) + 65'(prod_ff.p_ir);
         end
         FUNC_DIV: begin
            sre = 65'(prod_ff.p_rr) + 65'(prod_ff.p_ii);
            sim = 65'(prod_ff.p_ir) - 65'(prod_ff.p_ri);
         end
         default: begin
            sre = 65'(prod_ff.s_re);
            sim = 65'(prod_ff.s_im);
         end
      endcase
      den = $unsigned(prod_ff.p_bb_r) + $unsigned(prod_ff.p_bb_i);
      are = sre[64] ? -sre : sre;
      aim = sim[64] ? -sim : sim;

      st_in.is_div = (prod_ff.func == FUNC_DIV);
      st_in.dz     = (prod_ff.func == FUNC_DIV) && (den == 64'd0);
      st_in.den    = den;
      st_in.re.neg = sre[64];
      st_in.im.neg = sim[64];
      if (prod_ff.func == FUNC_MUL) begin
         st_in.re.mag = are[63:0] >> 16;
         st_in.im.mag = aim[63:0] >> 16;
      end else begin
         st_in.re.mag = are[63:0];
         st_in.im.mag = aim[63:0];
      end
      st_in.re.rem = {17'd0, are[63:0], 16'd0};
      st_in.im.rem = {17'd0, aim[63:0], 16'd0};
      st_in.re.quo = '0;
      st_in.im.quo = '0;
      st_in.re.big = 1'b0;
      st_in.im.big = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
      if (rdy1) begin
         prod_ff <= prod_in;
      end
      if (rdy2) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = st_ff;

endmodule

// ===== sv/cau_div.sv =====
module cau_div
   import cau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  cau_stage_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output cau_stage_type out_data
);

   cau_stage_type          st_ff [DIV_STAGES];
   cau_stage_type          st_in [DIV_STAGES];
   logic [DIV_STAGES-1:0]  v_ff;
   logic [DIV_STAGES:0]    rdy;

   assign rdy[DIV_STAGES] = out_ready;

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         // stage k settles quotient bit (QUO_W-1-k)
         localparam int SH = QUO_W - 1 - k;
         cau_stage_type src;
         logic          v_src;
         logic [REM_W-1:0] dsh;

         assign rdy[k] = !v_ff[k] || rdy[k+1];

         if (k == 0) begin : g_first
            assign src   = in_data;
            assign v_src = in_valid;
         end else begin : g_rest
            assign src   = st_ff[k-1];
            assign v_src = v_ff[k-1];
         end

         assign dsh = REM_W'(src.den) << SH;

         always_comb begin
            st_in[k]    = src;
            st_in[k].re = div_step(src.re, dsh);
            st_in[k].im = div_step(src.im, dsh);
            if (k == 0) begin
               // quotient would need more than 33 bits: saturates anyway
               st_in[k].re.big = (src.re.rem >= {src.den, {QUO_W{1'b0}}});
               st_in[k].im.big = (src.im.rem >= {src.den, {QUO_W{1'b0}}});
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               v_ff[k] <= v_src;
            end
            if (rdy[k]) begin
               st_ff[k] <= st_in[k];
            end
         end
      end
   endgenerate

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_data  = st_ff[DIV_STAGES-1];

endmodule

// ===== sv/cau_sat.sv =====
`include "complex_arith_unit_top_macros.svh"

module cau_sat
   import cau_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cau_stage_type       in_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_res_re,
   output logic signed [31:0]  rsp_res_im,
   output logic                rsp_overflow,
   output logic                rsp_div_zero
);

   logic        valid_ff;
   logic [31:0] re_ff, re_in, im_ff, im_in;
   logic        ovf_ff, ovf_in, dz_ff;

   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      logic [63:0] mre, mim;
      logic        o_re, o_im;
      if (in_data.is_div) begin
         mre = in_data.re.big ? 64'hFFFF_FFFF_FFFF : 64'(in_data.re.quo);
         mim = in_data.im.big ? 64'hFFFF_FFFF_FFFF : 64'(in_data.im.quo);
      end else begin
         mre = in_data.re.mag;
         mim = in_data.im.mag;
      end
      re_in  = sat32(in_data.re.neg, mre, o_re);
      im_in  = sat32(in_data.im.neg, mim, o_im);
      ovf_in = o_re || o_im;
      if (in_data.dz) begin
         re_in  = '0;
         im_in  = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         re_ff  <= re_in;
         im_ff  <= im_in;
         ovf_ff <= ovf_in;
         dz_ff  <= in_data.dz;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_res_re   = re_ff;
   assign rsp_res_im   = im_ff;
   assign rsp_overflow = ovf_ff;
   assign rsp_div_zero = dz_ff;

   `CAU_ASSERT_IMPL(a_dz_zero, rsp_valid && rsp_div_zero, rsp_res_re == 0 && rsp_res_im == 0 && !rsp_overflow)
   `CAU_ASSERT_IMPL(a_ovf_sat, rsp_valid && rsp_overflow, rsp_res_re == SAT_POS || rsp_res_re == SAT_NEG || rsp_res_im == SAT_POS || rsp_res_im == SAT_NEG)
   `CAU_ASSERT_NEXT(a_load, in_valid && in_ready, rsp_valid)

endmodule

// ===== dv/tb_complex_arith_unit_top.sv =====
`default_nettype none

module tb_complex_arith_unit_top
   import cau_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM  = 500;
   localparam int LATENCY     = 36;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      logic        ovf;
      logic        dz;
   } cplx_result_type;

   typedef struct {
      logic [1:0]      func;
      logic [31:0]     a_re;
      logic [31:0]     a_im;
      logic [31:0]     b_re;
      logic [31:0]     b_im;
      logic            known;  // expected result typed in below
      cplx_result_type res;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic signed [31:0] req_a_re, req_a_im, req_b_re, req_b_im;
   logic        rsp_valid;
   logic        rsp_ready;
   logic signed [31:0] rsp_res_re, rsp_res_im;
   logic        rsp_overflow;
   logic        rsp_div_zero;

   cplx_result_type pending_results[$];
   int          mismatches;
   int          transfers_in;
   int          transfers_out;
   int          cycle_count;
   bit          hold_off;
   bit          stim_done;
   int          n_ovf, n_dz;

   complex_arith_unit_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_a_re(req_a_re), .req_a_im(req_a_im), .req_b_re(req_b_re), .req_b_im(req_b_im),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_res_re(rsp_res_re), .rsp_res_im(rsp_res_im),
      .rsp_overflow(rsp_overflow), .rsp_div_zero(rsp_div_zero)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // sign/magnitude to saturated 32-bit pattern
   function automatic logic [31:0] clamp_q16(logic neg, logic [63:0] mag, ref logic ovf);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            ovf = 1'b1;
            return SAT_NEG;
         end
         return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         ovf = 1'b1;
         return SAT_POS;
      end
      return mag[31:0];
   endfunction

   // exact wide sum split into sign and magnitude
   function automatic void split_sum(logic signed [65:0] s, ref logic neg,
                                     ref logic [63:0] mag);
      logic signed [65:0] m;
      neg = s < 0;
      m = neg ? -s : s;
      mag = (m > 66'sh0_FFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : m[63:0];
   endfunction

   function automatic cplx_result_type predict_cplx(logic [1:0] func, logic signed [31:0] ar,
                                                    logic signed [31:0] ai,
                                                    logic signed [31:0] br,
                                                    logic signed [31:0] bi);
      cplx_result_type r;
      logic signed [65:0] sre, sim;
      logic [65:0] den;
      logic [81:0] qre, qim;
      logic nre, nim;
      logic [63:0] mre, mim;
      logic ovf;
      ovf = 1'b0;
      r.dz = 1'b0;
      sre = 0;
      sim = 0;
      case (func)
         FUNC_ADD: begin
            sre = 66'(ar) + 66'(br);
            sim = 66'(ai) + 66'(bi);
         end
         FUNC_SUB: begin
            sre = 66'(ar) - 66'(br);
            sim = 66'(ai) - 66'(bi);
         end
         FUNC_MUL: begin
            sre = 66'(ar) * 66'(br) - 66'(ai) * 66'(bi);
            sim = 66'(ar) * 66'(bi) + 66'(ai) * 66'(br);
         end
         default: begin
            sre = 66'(ar) * 66'(br) + 66'(ai) * 66'(bi);
            sim = 66'(ai) * 66'(br) - 66'(ar) * 66'(bi);
         end
      endcase
      split_sum(sre, nre, mre);
      split_sum(sim, nim, mim);
      if (func == FUNC_MUL) begin
         mre = mre >> 16;
         mim = mim >> 16;
      end else if (func == FUNC_DIV) begin
         den = 66'(66'(br) * 66'(br)) + 66'(66'(bi) * 66'(bi));
         if (den == 0) begin
            r.dz = 1'b1;
            nre = 0; nim = 0; mre = 0; mim = 0;
         end else begin
            qre = {mre, 16'h0} / 82'(den);
            qim = {mim, 16'h0} / 82'(den);
            mre = (qre > 82'hFFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : qre[63:0];
            mim = (qim > 82'hFFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : qim[63:0];
         end
      end
      r.re = clamp_q16(nre, mre, ovf);
      r.im = clamp_q16(nim, mim, ovf);
      r.ovf = ovf;
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed(16'($urandom())));        // small, mostly fraction
         3: return 32'($signed(24'($urandom())));
         4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom())};
         5: return 32'h0;
         default: return $urandom();
      endcase
   endfunction

   // Directed rows; known rows carry their expected result typed into the row.
   stim_row_type directed[$];

   task automatic add_row(logic [1:0] f, logic [31:0] ar, logic [31:0] ai, logic [31:0] br,
                          logic [31:0] bi, logic known, logic [31:0] rre, logic [31:0] rim,
                          logic ovf, logic dz);
      stim_row_type s;
      s.func = f; s.a_re = ar; s.a_im = ai; s.b_re = br; s.b_im = bi;
      s.known = known;
      s.res.re = rre; s.res.im = rim; s.res.ovf = ovf; s.res.dz = dz;
      directed.push_back(s);
   endtask

   task automatic build_directed();
      add_row(FUNC_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'hFFFF_FFFF, 1,
              SAT_POS, SAT_NEG, 1, 0);
      add_row(FUNC_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 1,
              SAT_NEG, SAT_POS, 1, 0);
      add_row(FUNC_SUB, 5, 7, 2, 3, 1, 3, 4, 0, 0);
      add_row(FUNC_DIV, 32'h1234_5678, 32'h8000_0000, 0, 0, 1, 0, 0, 0, 1);
      add_row(FUNC_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1, 0, 0, 0, 1);
      add_row(FUNC_MUL, 32'h0001_0000, 0, 32'h0001_0000, 0, 1, 32'h0001_0000, 0, 0, 0);
      add_row(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
              0, 0, 0, 0);
      add_row(FUNC_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
              0, 0, 0, 0);
      add_row(FUNC_MUL, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0, 0, 0);  // truncation toward zero
      add_row(FUNC_MUL, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'hFFFF_8000, 0,
              0, 0, 0, 0);
      add_row(FUNC_DIV, 32'h0001_0000, 0, 32'h0001_0000, 0, 1, 32'h0001_0000, 0, 0, 0);
      add_row(FUNC_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
              0, 0, 0, 0);
      add_row(FUNC_DIV, 32'h8000_0000, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_DIV, 32'hFFFF_FFFF, 3, 32'h0003_0000, 32'hFFFD_0000, 0, 0, 0, 0, 0);
      add_row(FUNC_DIV, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0);
      add_row(FUNC_DIV, 32'h0003_0000, 32'h0004_0000, 0, 32'h0000_0001, 0, 0, 0, 0, 0);
   endtask

   task automatic send_item(logic [1:0] f, logic [31:0] ar, logic [31:0] ai, logic [31:0] br,
                            logic [31:0] bi, cplx_result_type exp_res);
      req_valid <= 1'b1;
      req_func  <= f;
      req_a_re  <= ar; req_a_im <= ai; req_b_re <= br; req_b_im <= bi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(exp_res);
      transfers_in++;
   endtask

   task automatic go_idle(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // sender
   initial begin
      int burst;
      logic [1:0] f;
      logic [31:0] ar, ai, br, bi;
      cplx_result_type pr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = '0;
      req_a_re = '0; req_a_im = '0; req_b_re = '0; req_b_im = '0;
      stim_done = 1'b0;
      build_directed();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         pr = predict_cplx(directed[i].func, directed[i].a_re, directed[i].a_im,
                           directed[i].b_re, directed[i].b_im);
         if (directed[i].known) pr = directed[i].res;
         send_item(directed[i].func, directed[i].a_re, directed[i].a_im,
                   directed[i].b_re, directed[i].b_im, pr);
         if ($urandom_range(0, 3) == 0) go_idle($urandom_range(1, 3));
      end
      // drain fully before the random part
      go_idle(0);
      while (pending_results.size() != 0) @(posedge clock);
      for (int n = 0; n < NUM_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
            f = 2'($urandom());
            ar = rand_operand(); ai = rand_operand();
            br = rand_operand(); bi = rand_operand();
            if (f == FUNC_DIV && $urandom_range(0, 15) == 0) begin
               br = 0;
               bi = 0;
            end
            send_item(f, ar, ai, br, bi, predict_cplx(f, ar, ai, br, bi));
         end
         if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 6));
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver: random stall pattern plus one long hold-off
   initial begin
      rsp_ready = 1'b0;
      hold_off = 1'b0;
      @(negedge reset);
      while (transfers_in < 60) @(posedge clock);
      hold_off = 1'b1;
      repeat (150) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_ready <= 1'b0;
      end else if ((cycle_count / 64) % 3 == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // response checker
   always @(posedge clock) begin
      cplx_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         transfers_out++;
         if (rsp_overflow) n_ovf++;
         if (rsp_div_zero) n_dz++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer at cycle %0d", cycle_count);
         end else begin
            e = pending_results.pop_front();
            if (rsp_res_re !== e.re || rsp_res_im !== e.im ||
                rsp_overflow !== e.ovf || rsp_div_zero !== e.dz) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: exp %h %h %b %b got %h %h %b %b",
                           transfers_out, e.re, e.im, e.ovf, e.dz, rsp_res_re, rsp_res_im,
                           rsp_overflow, rsp_div_zero);
            end
         end
      end
   end

   initial begin
      mismatches = 0; transfers_in = 0; transfers_out = 0; n_ovf = 0; n_dz = 0;
      cycle_count = 0;
      fork
         begin
            wait (stim_done);
            while (pending_results.size() != 0) @(posedge clock);
            repeat (LATENCY + 4) @(posedge clock);
            $display("%0d items in, %0d results out; %0d saturated, %0d zero-divisor",
                     transfers_in, transfers_out, n_ovf, n_dz);
            if (mismatches == 0 && pending_results.size() == 0) begin
               $display("end of test: clean");
            end else begin
               $display("end of test: mismatches");
            end
            $finish;
         end
         begin
            while (cycle_count < CYCLE_LIMIT) begin
               @(posedge clock);
               cycle_count++;
            end
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
         end
      join
   end

endmodule

`default_nettype wire
